// ===== design/markup_tag_scanner_unit_macros.svh =====
// Assertion macros shared by the markup tag scanner checkers.
// Depends on nothing; included by the checker file.
`ifndef MARKUP_TAG_SCANNER_UNIT_MACROS_SVH
`define MARKUP_TAG_SCANNER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define MTS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define MTS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/mts_pkg.sv =====
// Types, codes and byte classes of the markup tag scanner.
// Depends on nothing; used by every module of the block.
`default_nettype none

package mts_pkg;

  localparam int MAX_LEN_DEF = 4096;

  localparam int RQ_DEPTH = 4;
  localparam int RQ_AW    = $clog2(RQ_DEPTH);

  localparam logic [1:0] KIND_ATTR = 2'd0;
  localparam logic [1:0] KIND_TAG  = 2'd1;
  localparam logic [1:0] KIND_NONE = 2'd2;

  localparam logic [1:0] SYN_OPEN  = 2'd0;
  localparam logic [1:0] SYN_CLOSE = 2'd1;
  localparam logic [1:0] SYN_SELF  = 2'd2;

  localparam logic [1:0] QC_NONE   = 2'd0;
  localparam logic [1:0] QC_SINGLE = 2'd1;
  localparam logic [1:0] QC_DOUBLE = 2'd2;

  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_USCORE = 8'h5F;
  localparam logic [7:0] CH_ASCII_TOP = 8'd127;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       buffer_start;
    logic       buffer_end;
  } mts_in_t;

  typedef struct packed {
    logic [1:0]  report_kind;
    logic [11:0] name_offset;
    logic [12:0] name_length;
    logic [11:0] value_offset;
    logic [12:0] value_length;
    logic [12:0] tag_length;
    logic [1:0]  syntax_type;
    logic        suspicious;
    logic        last_report;
  } mts_out_t;

  typedef struct packed {
    logic v0;
    logic v1;
  } mts_push_t;

  function automatic logic is_letter(input logic [7:0] c);
    return c inside {[8'h61:8'h7A], [8'h41:8'h5A]};
  endfunction

  function automatic logic is_name_byte(input logic [7:0] c);
    return is_letter(c) || (c inside {[8'h30:8'h39], CH_DASH, CH_DOT, CH_USCORE}) ||
           (c > CH_ASCII_TOP);
  endfunction

  function automatic logic [1:0] quote_code(input logic [7:0] c);
    logic [1:0] q;
    q = QC_NONE;
    if (c == CH_SQUOTE) q = QC_SINGLE;
    else if (c == CH_DQUOTE) q = QC_DOUBLE;
    return q;
  endfunction

  function automatic mts_out_t make_res(input logic [1:0] kind, input logic [11:0] noff,
                                        input logic [12:0] nlen, input logic [11:0] voff,
                                        input logic [12:0] vlen, input logic [12:0] tlen,
                                        input logic [1:0] styp, input logic susp,
                                        input logic last);
    mts_out_t r;
    r.report_kind  = kind;
    r.name_offset  = noff;
    r.name_length  = nlen;
    r.value_offset = voff;
    r.value_length = vlen;
    r.tag_length   = tlen;
    r.syntax_type  = styp;
    r.suspicious   = susp;
    r.last_report  = last;
    return r;
  endfunction

  function automatic mts_out_t no_tag_res();
    return make_res(KIND_NONE, 12'd0, 13'd0, 12'd0, 13'd0, 13'd0, SYN_OPEN, 1'b0, 1'b1);
  endfunction

endpackage

`default_nettype wire

// ===== design/markup_tag_scanner_unit.sv =====
// Top level of the markup tag scanner: input register, scan logic, result queue.
// Depends on mts_pkg, mts_scan and mts_rqueue.
//
// The input channel carries one buffer byte per transfer, with flags that mark
// the first and the last byte of a buffer. A first byte restarts the scan.
// The result channel carries reports: one for each attribute found, then a
// final report (tag complete or no tag) with last_report set.
// Each byte causes zero, one or two reports.
// Throughput is one byte per cycle while the receiver takes results. A byte is
// held in the input register, where the scan logic updates the scan state and
// writes its reports into a four-entry result queue; a report shows on the
// result channel once the queue has registered it.
// The input register waits while the queue has fewer than two free entries, so
// a stalled receiver backs up into in_stall once three reports are waiting.
// The result at the head of the queue holds while out_stall is high.
// Reset empties the queue and the input register and puts the scanner in its
// waiting state; bytes without a buffer start then give no reports.
`default_nettype none

module markup_tag_scanner_unit #(
  parameter int MAX_LEN = mts_pkg::MAX_LEN_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire mts_pkg::mts_in_t  in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output mts_pkg::mts_out_t      out_data
);

  logic               in_vld_r;
  mts_pkg::mts_in_t   in_data_r;
  logic               room;
  logic               go;
  mts_pkg::mts_push_t push;
  mts_pkg::mts_out_t  res0;
  mts_pkg::mts_out_t  res1;

  assign go       = in_vld_r && room;
  assign in_stall = in_vld_r && !room;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (!in_stall) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) in_data_r <= in_data;
  end

  mts_scan #(
    .MAX_LEN (MAX_LEN)
  ) u_scan (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (go),
    .item  (in_data_r),
    .push  (push),
    .res0  (res0),
    .res1  (res1)
  );

  mts_rqueue u_rqueue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .res0      (res0),
    .res1      (res1),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ===== design/mts_scan.sv =====
// Per-byte scan logic and scan state of the markup tag scanner.
// Depends on mts_pkg; instantiated by markup_tag_scanner_unit.
`default_nettype none

module mts_scan #(
  parameter int MAX_LEN = mts_pkg::MAX_LEN_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              go,
  input  wire mts_pkg::mts_in_t  item,
  output mts_pkg::mts_push_t     push,
  output mts_pkg::mts_out_t      res0,
  output mts_pkg::mts_out_t      res1
);

  localparam int POS_W = $clog2(MAX_LEN + 1);
  localparam int LW    = (POS_W > 13) ? POS_W : 13;

  typedef enum logic [2:0] {
    PH_IDLE, PH_AFTER_LT, PH_SKIP, PH_NAME, PH_ATTR, PH_DONE
  } phase_t;

  phase_t             ph_r, ph_nxt;
  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic [1:0]         qc_r, qc_nxt;
  logic [1:0]         tt_r, tt_nxt;
  logic [POS_W-1:0]   tno_r, tno_nxt;
  logic [POS_W-1:0]   tnl_r, tnl_nxt;
  logic [POS_W-1:0]   aso_r, aso_nxt;
  logic [POS_W-1:0]   ane_r, ane_nxt;
  logic [POS_W-1:0]   avo_r, avo_nxt;
  logic               ae_r, ae_nxt;
  logic               sq_r, sq_nxt;

  mts_pkg::mts_out_t  res [2];
  logic [1:0]         k;
  logic [7:0]         c;
  logic [1:0]         q;
  logic [POS_W-1:0]   ip1;
  logic [POS_W-1:0]   ne;
  logic               do_attr;
  logic               scanned;
  logic               blank2;
  logic               blank4;

  function automatic logic [11:0] off12(input logic [POS_W-1:0] x);
    logic [LW-1:0] t;
    t = LW'(x);
    return t[11:0];
  endfunction

  function automatic logic [12:0] dif13(input logic [POS_W-1:0] a,
                                        input logic [POS_W-1:0] b);
    logic [LW-1:0] t;
    t = LW'(a) - LW'(b);
    return t[12:0];
  endfunction

  always_comb begin
    ph_nxt  = ph_r;
    pos_nxt = pos_r;
    qc_nxt  = qc_r;
    tt_nxt  = tt_r;
    tno_nxt = tno_r;
    tnl_nxt = tnl_r;
    aso_nxt = aso_r;
    ane_nxt = ane_r;
    avo_nxt = avo_r;
    ae_nxt  = ae_r;
    sq_nxt  = sq_r;
    res[0]  = '0;
    res[1]  = '0;
    k       = 2'd0;
    do_attr = 1'b0;
    scanned = 1'b0;
    ne      = '0;
    c       = item.data_byte;
    q       = mts_pkg::quote_code(c);
    ip1     = pos_r + POS_W'(1);
    blank2  = (c == mts_pkg::CH_SPACE) || (c == mts_pkg::CH_TAB);
    blank4  = blank2 || (c == mts_pkg::CH_CR) || (c == mts_pkg::CH_LF);

    if (item.buffer_start) begin
      pos_nxt = '0;
      qc_nxt  = mts_pkg::QC_NONE;
      tt_nxt  = mts_pkg::SYN_OPEN;
      tno_nxt = '0;
      tnl_nxt = '0;
      aso_nxt = '0;
      ane_nxt = '0;
      avo_nxt = '0;
      ae_nxt  = 1'b0;
      sq_nxt  = 1'b0;
      if ((c != mts_pkg::CH_LT) || item.buffer_end) begin
        res[k[0]] = mts_pkg::no_tag_res();
        k = k + 2'd1;
        ph_nxt = PH_DONE;
      end else begin
        ph_nxt  = PH_AFTER_LT;
        pos_nxt = POS_W'(1);
      end
    end else if ((ph_r == PH_IDLE) || (ph_r == PH_DONE)) begin
      ph_nxt = ph_r;
    end else if (pos_r >= POS_W'(MAX_LEN)) begin
      res[k[0]] = mts_pkg::no_tag_res();
      k = k + 2'd1;
      ph_nxt = PH_DONE;
    end else begin
      scanned = 1'b1;
      case (ph_r)
        PH_AFTER_LT: begin
          if (blank2) begin
            res[k[0]] = mts_pkg::no_tag_res();
            k = k + 2'd1;
            ph_nxt = PH_DONE;
            scanned = 1'b0;
          end else if (c == mts_pkg::CH_SLASH) begin
            tt_nxt = mts_pkg::SYN_CLOSE;
            ph_nxt = PH_SKIP;
          end else if (mts_pkg::is_letter(c)) begin
            tno_nxt = pos_r;
            tnl_nxt = POS_W'(1);
            ph_nxt  = PH_NAME;
          end else begin
            tno_nxt = '0;
            tnl_nxt = '0;
            ph_nxt  = PH_ATTR;
          end
        end
        PH_SKIP: begin
          if (!blank2) begin
            if (mts_pkg::is_letter(c)) begin
              tno_nxt = pos_r;
              tnl_nxt = POS_W'(1);
              ph_nxt  = PH_NAME;
            end else begin
              tno_nxt = '0;
              tnl_nxt = '0;
              ph_nxt  = PH_ATTR;
            end
          end
        end
        PH_NAME: begin
          if (mts_pkg::is_name_byte(c)) begin
            tnl_nxt = tnl_r + POS_W'(1);
          end else begin
            ph_nxt  = PH_ATTR;
            do_attr = 1'b1;
          end
        end
        PH_ATTR: begin
          do_attr = 1'b1;
        end
        default: begin
          scanned = 1'b0;
        end
      endcase

      if (do_attr) begin
        if ((qc_r == mts_pkg::QC_NONE) && (q != mts_pkg::QC_NONE) && ae_r) begin
          ae_nxt  = 1'b0;
          qc_nxt  = q;
          avo_nxt = pos_r;
        end else if ((qc_r != mts_pkg::QC_NONE) && (qc_r == q)) begin
          res[k[0]] = mts_pkg::make_res(mts_pkg::KIND_ATTR, off12(aso_r),
                                        dif13(ane_r, aso_r), off12(avo_r),
                                        dif13(ip1, avo_r), 13'd0, mts_pkg::SYN_OPEN,
                                        1'b0, 1'b0);
          k = k + 2'd1;
          ae_nxt  = 1'b0;
          qc_nxt  = mts_pkg::QC_NONE;
          aso_nxt = '0;
          ane_nxt = '0;
          avo_nxt = '0;
        end else if (qc_r != mts_pkg::QC_NONE) begin
          qc_nxt = qc_r;
        end else if ((c == mts_pkg::CH_GT) || (c == mts_pkg::CH_SLASH)) begin
          if (aso_r != '0) begin
            ne = (ane_r == '0) ? pos_r : ane_r;
            res[k[0]] = mts_pkg::make_res(mts_pkg::KIND_ATTR, off12(aso_r),
                                          dif13(ne, aso_r), 12'd0, 13'd0, 13'd0,
                                          mts_pkg::SYN_OPEN, 1'b0, 1'b0);
            k = k + 2'd1;
            ane_nxt = ne;
          end
          ae_nxt = 1'b0;
          if (c == mts_pkg::CH_GT) begin
            ph_nxt = PH_DONE;
            res[k[0]] = mts_pkg::make_res(mts_pkg::KIND_TAG, off12(tno_r),
                                          dif13(tnl_r, {POS_W{1'b0}}), 12'd0, 13'd0,
                                          dif13(ip1, {POS_W{1'b0}}), tt_r, sq_r, 1'b1);
            k = k + 2'd1;
          end else begin
            if (tt_r == mts_pkg::SYN_OPEN) tt_nxt = mts_pkg::SYN_SELF;
            aso_nxt = '0;
            ane_nxt = '0;
            avo_nxt = '0;
          end
        end else if ((c == mts_pkg::CH_EQ) && (aso_r != '0)) begin
          ae_nxt = 1'b1;
          if (ane_r == '0) ane_nxt = pos_r;
        end else if (blank4) begin
          if (aso_r != '0) ane_nxt = pos_r;
        end else begin
          ae_nxt = 1'b0;
          if (q != mts_pkg::QC_NONE) sq_nxt = 1'b1;
          if ((aso_r == '0) || (ane_r != '0)) begin
            if (ane_r != '0) begin
              res[k[0]] = mts_pkg::make_res(mts_pkg::KIND_ATTR, off12(aso_r),
                                            dif13(ane_r, aso_r), 12'd0, 13'd0, 13'd0,
                                            mts_pkg::SYN_OPEN, 1'b0, 1'b0);
              k = k + 2'd1;
            end
            aso_nxt = pos_r;
            ane_nxt = '0;
          end
        end
      end

      if (scanned && (ph_nxt != PH_DONE)) begin
        pos_nxt = ip1;
        if (item.buffer_end) begin
          res[k[0]] = mts_pkg::no_tag_res();
          k = k + 2'd1;
          ph_nxt = PH_DONE;
        end
      end
    end
  end

  assign push.v0 = go && (k != 2'd0);
  assign push.v1 = go && (k == 2'd2);
  assign res0    = res[0];
  assign res1    = res[1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r  <= PH_IDLE;
      pos_r <= '0;
      qc_r  <= mts_pkg::QC_NONE;
      tt_r  <= mts_pkg::SYN_OPEN;
      tno_r <= '0;
      tnl_r <= '0;
      aso_r <= '0;
      ane_r <= '0;
      avo_r <= '0;
      ae_r  <= 1'b0;
      sq_r  <= 1'b0;
    end else if (go) begin
      ph_r  <= ph_nxt;
      pos_r <= pos_nxt;
      qc_r  <= qc_nxt;
      tt_r  <= tt_nxt;
      tno_r <= tno_nxt;
      tnl_r <= tnl_nxt;
      aso_r <= aso_nxt;
      ane_r <= ane_nxt;
      avo_r <= avo_nxt;
      ae_r  <= ae_nxt;
      sq_r  <= sq_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== design/mts_rqueue.sv =====
// Result queue of the markup tag scanner: takes up to two reports a cycle.
// Depends on mts_pkg; instantiated by markup_tag_scanner_unit.
`default_nettype none

module mts_rqueue (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire mts_pkg::mts_push_t push,
  input  wire mts_pkg::mts_out_t  res0,
  input  wire mts_pkg::mts_out_t  res1,
  output logic                    room,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output mts_pkg::mts_out_t       out_data
);

  localparam int AW = mts_pkg::RQ_AW;
  localparam int CW = mts_pkg::RQ_AW + 1;

  mts_pkg::mts_out_t mem [mts_pkg::RQ_DEPTH];
  logic [AW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [AW-1:0]     wr_ptr1;
  logic              pop;

  assign pop        = out_valid && !out_stall;
  assign wr_ptr1    = wr_ptr_r + AW'(1);
  assign wr_ptr_nxt = wr_ptr_r + AW'(push.v0) + AW'(push.v1);
  assign rd_ptr_nxt = rd_ptr_r + AW'(pop);
  assign cnt_nxt    = cnt_r + CW'(push.v0) + CW'(push.v1) - CW'(pop);
  assign room       = cnt_r <= CW'(mts_pkg::RQ_DEPTH - 2);
  assign out_valid  = cnt_r != '0;
  assign out_data   = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push.v0) mem[wr_ptr_r] <= res0;
    if (push.v1) mem[wr_ptr1] <= res1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== design/mts_checker.sv =====
// Port-level checks of the markup tag scanner, bound to its top level.
// Depends on mts_pkg and markup_tag_scanner_unit_macros.svh.
`default_nettype none

`include "markup_tag_scanner_unit_macros.svh"

module mts_checker (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_stall,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input wire mts_pkg::mts_out_t out_data
);

  logic out_wait;
  logic out_final;
  logic out_attr;
  logic attr_clean;
  logic kind_known;

  assign out_wait   = out_valid && out_stall;
  assign out_final  = out_valid && ((out_data.report_kind == mts_pkg::KIND_TAG) ||
                                    (out_data.report_kind == mts_pkg::KIND_NONE));
  assign out_attr   = out_valid && (out_data.report_kind == mts_pkg::KIND_ATTR);
  assign attr_clean = !out_data.last_report && (out_data.tag_length == 13'd0) &&
                      (out_data.syntax_type == mts_pkg::SYN_OPEN) && !out_data.suspicious;
  assign kind_known = (out_data.report_kind == mts_pkg::KIND_ATTR) ||
                      (out_data.report_kind == mts_pkg::KIND_TAG) ||
                      (out_data.report_kind == mts_pkg::KIND_NONE);

  `MTS_ASSERT_NEXT(a_hold, clk, rst_n, out_wait, out_valid && $stable(out_data), "held data moved")
  `MTS_ASSERT_NOW(a_final_last, clk, rst_n, out_final, out_data.last_report, "last flag missing")
  `MTS_ASSERT_NOW(a_attr_fields, clk, rst_n, out_attr, attr_clean, "attribute has tag fields")
  `MTS_ASSERT_NOW(a_kind_code, clk, rst_n, out_valid, kind_known, "undefined report kind")
  `MTS_ASSERT_NOW(a_reset_ready, clk, rst_n, !$past(rst_n), !in_stall, "stall after reset")

endmodule

bind markup_tag_scanner_unit mts_checker u_mts_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire
